FILE: hdl/baro_pkg.sv
// shared types and helpers for barometer compensation
`default_nettype none
package baro_pkg;
    localparam int unsigned DivSteps = 32;

    localparam logic [1:0] RegTempCal  = 2'd0;
    localparam logic [1:0] RegPresLow  = 2'd1;
    localparam logic [1:0] RegPresHigh = 2'd2;
    localparam logic [1:0] RegPresNine = 2'd3;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] tfine;
        logic [31:0] numer;
        logic [31:0] denom;
        logic        big;
        logic        invalid;
    } t_div_in;

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
        asr = 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction
endpackage
`default_nettype wire

FILE: hdl/baro_divider.sv
// pipelined restoring 32-bit unsigned divider, one quotient bit per stage
`default_nettype none
module baro_divider (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire logic                 i_valid,
    input  wire baro_pkg::t_div_in    i_data,
    output logic                      o_valid,
    output baro_pkg::t_div_in         o_data,
    output logic [31:0]               o_quot
);
    localparam int unsigned N = baro_pkg::DivSteps;
    logic [N:0]       r_v;
    baro_pkg::t_div_in r_d [N+1];
    logic [31:0]      r_rem [N+1];
    logic [31:0]      r_q   [N+1];
    logic [31:0]      n_rem [N];
    logic [31:0]      n_q   [N];

    always_comb begin
        logic [32:0] t;
        for (int k = 0; k < N; k++) begin
            t = {r_rem[k], r_q[k][31]};
            if (t >= {1'b0, r_d[k].denom}) begin
                t = t - {1'b0, r_d[k].denom};
                n_q[k] = {r_q[k][30:0], 1'b1};
            end else begin
                n_q[k] = {r_q[k][30:0], 1'b0};
            end
            n_rem[k] = t[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[N-1:0], i_valid};
        end
        if (i_adv) begin
            r_d[0]   <= i_data;
            r_rem[0] <= '0;
            r_q[0]   <= i_data.numer;
            for (int k = 0; k < N; k++) begin
                r_d[k+1]   <= r_d[k];
                r_rem[k+1] <= n_rem[k];
                r_q[k+1]   <= n_q[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_data  = r_d[N];
    assign o_quot  = r_q[N];
endmodule
`default_nettype wire

FILE: hdl/baro_sensor_compensation_top.sv
// Barometer compensation: one sample pair accepted per cycle unless o_stall is
// high, one result per pair from seven temperature and pre-divide stages, a
// 33-stage pipelined divider, three post-divide stages and the output register.
// A stall on the output first fills a one-entry skid register; only then is the
// whole pipeline frozen and the input stalled.
`default_nettype none
module baro_sensor_compensation_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [19:0] i_raw_temperature,
    input  wire logic [19:0] i_raw_pressure,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_temperature_centi,
    output logic signed [31:0] o_fine_temperature,
    output logic [31:0]      o_pressure_pa,
    output logic             o_pressure_invalid
);
    logic [47:0] r_tc;
    logic [63:0] r_pl, r_ph;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0; r_pl <= '0; r_ph <= '0; r_p9 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                baro_pkg::RegTempCal:  r_tc <= i_cfg_data[47:0];
                baro_pkg::RegPresLow:  r_pl <= i_cfg_data;
                baro_pkg::RegPresHigh: r_ph <= i_cfg_data;
                baro_pkg::RegPresNine: r_p9 <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_tc[15:0]};
    assign t2 = baro_pkg::sx16(r_tc[31:16]);
    assign t3 = baro_pkg::sx16(r_tc[47:32]);
    assign p1 = {16'd0, r_pl[15:0]};
    assign p2 = baro_pkg::sx16(r_pl[31:16]);
    assign p3 = baro_pkg::sx16(r_pl[47:32]);
    assign p4 = baro_pkg::sx16(r_pl[63:48]);
    assign p5 = baro_pkg::sx16(r_ph[15:0]);
    assign p6 = baro_pkg::sx16(r_ph[31:16]);
    assign p7 = baro_pkg::sx16(r_ph[47:32]);
    assign p8 = baro_pkg::sx16(r_ph[63:48]);
    assign p9 = baro_pkg::sx16(r_p9);

    // output register with one-entry skid; pipeline advances while the skid is empty
    logic r_ov, r_sv, adv;
    assign adv = !r_sv;
    assign o_stall = !adv;

    // stage 1
    logic        r_s1_v;
    logic [19:0] r_s1_p;
    logic [31:0] r_s1_a, r_s1_dd;
    // stage 2
    logic        r_s2_v;
    logic [19:0] r_s2_p;
    logic [31:0] r_s2_a, r_s2_b;
    // stage 3
    logic        r_s3_v;
    logic [19:0] r_s3_p;
    logic [31:0] r_s3_tf, r_s3_t5;
    // stage 4
    logic        r_s4_v;
    logic [19:0] r_s4_p;
    logic [31:0] r_s4_tf, r_s4_tmp, r_s4_a, r_s4_sq;
    // stage 5
    logic        r_s5_v;
    logic [19:0] r_s5_p;
    logic [31:0] r_s5_tf, r_s5_tmp, r_s5_b6, r_s5_p3s, r_s5_ap5, r_s5_p2a;
    // stage 6
    logic        r_s6_v;
    logic [19:0] r_s6_p;
    logic [31:0] r_s6_tf, r_s6_tmp, r_s6_b, r_s6_a1;
    // stage 7
    logic        r_s7_v;
    logic [31:0] r_s7_tf, r_s7_tmp, r_s7_pn, r_s7_a;

    logic [31:0] d, b5, bb, ax, pn;
    always_comb begin
        d = 32'(i_raw_temperature >> 4) - t1;
        b5 = r_s5_b6 + (r_s5_ap5 << 1);
        bb = baro_pkg::asr(b5, 2) + (p4 << 16);
        ax = baro_pkg::asr(baro_pkg::asr(r_s5_p3s, 3) + baro_pkg::asr(r_s5_p2a, 1), 18);
        pn = (32'd1048576 - 32'(r_s6_p)) - baro_pkg::asr(r_s6_b, 12);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_s3_v <= 1'b0; r_s4_v <= 1'b0;
            r_s5_v <= 1'b0; r_s6_v <= 1'b0; r_s7_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= i_valid; r_s2_v <= r_s1_v; r_s3_v <= r_s2_v; r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v; r_s6_v <= r_s5_v; r_s7_v <= r_s6_v;
        end
        if (adv) begin
            r_s1_p  <= i_raw_pressure;
            r_s1_a  <= baro_pkg::asr(
                32'((32'(i_raw_temperature >> 3) - (t1 << 1)) * t2), 11);
            r_s1_dd <= 32'(d * d);
            r_s2_p  <= r_s1_p;
            r_s2_a  <= r_s1_a;
            r_s2_b  <= 32'(baro_pkg::asr(r_s1_dd, 12) * t3);
            r_s3_p  <= r_s2_p;
            r_s3_tf <= r_s2_a + baro_pkg::asr(r_s2_b, 14);
            r_s3_t5 <= 32'((r_s2_a + baro_pkg::asr(r_s2_b, 14)) * 32'd5);
            r_s4_p  <= r_s3_p;
            r_s4_tf <= r_s3_tf;
            r_s4_tmp <= baro_pkg::asr(r_s3_t5 + 32'd128, 8);
            r_s4_a  <= baro_pkg::asr(r_s3_tf, 1) - 32'd64000;
            r_s4_sq <= 32'(baro_pkg::asr(baro_pkg::asr(r_s3_tf, 1) - 32'd64000, 2)
                         * baro_pkg::asr(baro_pkg::asr(r_s3_tf, 1) - 32'd64000, 2));
            r_s5_p  <= r_s4_p;
            r_s5_tf <= r_s4_tf;
            r_s5_tmp <= r_s4_tmp;
            r_s5_b6 <= 32'(baro_pkg::asr(r_s4_sq, 11) * p6);
            r_s5_p3s <= 32'(p3 * baro_pkg::asr(r_s4_sq, 13));
            r_s5_ap5 <= 32'(r_s4_a * p5);
            r_s5_p2a <= 32'(p2 * r_s4_a);
            r_s6_p  <= r_s5_p;
            r_s6_tf <= r_s5_tf;
            r_s6_tmp <= r_s5_tmp;
            r_s6_b  <= bb;
            r_s6_a1 <= 32'((32'd32768 + ax) * p1);
            r_s7_tf <= r_s6_tf;
            r_s7_tmp <= r_s6_tmp;
            r_s7_pn <= 32'(pn * 32'd3125);
            r_s7_a  <= baro_pkg::asr(r_s6_a1, 15);
        end
    end

    baro_pkg::t_div_in div_in, div_out;
    logic              div_v;
    logic [31:0]       div_q;
    always_comb begin
        div_in.temp    = r_s7_tmp;
        div_in.tfine   = r_s7_tf;
        div_in.big     = r_s7_pn[31];
        div_in.numer   = r_s7_pn[31] ? r_s7_pn : (r_s7_pn << 1);
        div_in.denom   = (r_s7_a == '0) ? 32'd1 : r_s7_a;
        div_in.invalid = (r_s7_a == '0);
    end

    baro_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv), .i_valid(r_s7_v),
        .i_data(div_in), .o_valid(div_v), .o_data(div_out), .o_quot(div_q)
    );

    // post-divide stages
    logic        r_s8_v, r_s9_v, r_s10_v;
    logic [31:0] r_s8_tf, r_s8_tmp, r_s8_p, r_s8_pp, r_s8_b;
    logic        r_s8_inv;
    logic [31:0] r_s9_tf, r_s9_tmp, r_s9_p, r_s9_a, r_s9_b;
    logic        r_s9_inv;
    logic [31:0] r_s10_tf, r_s10_tmp, r_s10_p;
    logic        r_s10_inv;
    logic [31:0] pq, pf;

    always_comb begin
        pq = div_out.big ? (div_q << 1) : div_q;
        pf = r_s9_p + baro_pkg::asr(r_s9_a + r_s9_b + p7, 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0; r_s9_v <= 1'b0; r_s10_v <= 1'b0;
        end else if (adv) begin
            r_s8_v <= div_v; r_s9_v <= r_s8_v; r_s10_v <= r_s9_v;
        end
        if (adv) begin
            r_s8_tf <= div_out.tfine; r_s8_tmp <= div_out.temp;
            r_s8_inv <= div_out.invalid;
            r_s8_p  <= pq;
            r_s8_pp <= 32'((pq >> 3) * (pq >> 3));
            r_s8_b  <= 32'((pq >> 2) * p8);
            r_s9_tf <= r_s8_tf; r_s9_tmp <= r_s8_tmp; r_s9_inv <= r_s8_inv;
            r_s9_p <= r_s8_p;
            r_s9_a  <= baro_pkg::asr(32'(p9 * (r_s8_pp >> 13)), 12);
            r_s9_b  <= baro_pkg::asr(r_s8_b, 13);
            r_s10_tf <= r_s9_tf; r_s10_tmp <= r_s9_tmp; r_s10_inv <= r_s9_inv;
            r_s10_p <= r_s9_inv ? 32'd0 : pf;
        end
    end

    // output register plus skid
    logic [96:0] r_o, r_s, w_in;
    assign w_in = {r_s10_tmp, r_s10_tf, r_s10_p, r_s10_inv};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_sv <= 1'b0;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= r_sv || (adv && r_s10_v);
                r_sv <= 1'b0;
            end else if (!r_ov) begin
                r_ov <= adv && r_s10_v;
            end else if (adv && r_s10_v) begin
                r_sv <= 1'b1;
            end
        end
        if (r_ov && !i_stall) begin
            r_o <= r_sv ? r_s : w_in;
        end else if (!r_ov) begin
            r_o <= w_in;
        end else if (adv && r_s10_v) begin
            r_s <= w_in;
        end
    end

    assign o_valid             = r_ov;
    assign o_temperature_centi = r_o[96:65];
    assign o_fine_temperature  = r_o[64:33];
    assign o_pressure_pa       = r_o[32:1];
    assign o_pressure_invalid  = r_o[0];
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// testbench for the barometer compensation block: directed table plus random requests
`timescale 1ns / 1ps
module testbench;
    localparam int MAX_WAIT = 18;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [31:0] pres;
        logic        inv;
    } t_comp;

    typedef struct {
        int          cal_set;
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        bit          typed;
        t_comp       want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [19:0] i_raw_temperature;
    logic [19:0] i_raw_pressure;
    logic        o_valid;
    logic        i_stall;
    logic signed [31:0] o_temperature_centi;
    logic signed [31:0] o_fine_temperature;
    logic [31:0] o_pressure_pa;
    logic        o_pressure_invalid;

    logic [47:0] cal_temp;
    logic [63:0] cal_pres_low;
    logic [63:0] cal_pres_high;
    logic [15:0] cal_p9;

    t_comp pending_q[$];
    int    errors = 0;
    int    cycles = 0;
    bit    no_idle = 0;

    baro_sensor_compensation_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_raw_temperature(i_raw_temperature), .i_raw_pressure(i_raw_pressure),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_temperature_centi(o_temperature_centi), .o_fine_temperature(o_fine_temperature),
        .o_pressure_pa(o_pressure_pa), .o_pressure_invalid(o_pressure_invalid)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] shr_s(input logic [31:0] v, input int s);
        logic signed [31:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_comp compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
        logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, sq, p;
        t_comp r;
        adc_t = {12'b0, raw_t};
        adc_p = {12'b0, raw_p};
        t1 = {16'b0, cal_temp[15:0]};
        t2 = ext16(cal_temp[31:16]);
        t3 = ext16(cal_temp[47:32]);
        p1 = {16'b0, cal_pres_low[15:0]};
        p2 = ext16(cal_pres_low[31:16]);
        p3 = ext16(cal_pres_low[47:32]);
        p4 = ext16(cal_pres_low[63:48]);
        p5 = ext16(cal_pres_high[15:0]);
        p6 = ext16(cal_pres_high[31:16]);
        p7 = ext16(cal_pres_high[47:32]);
        p8 = ext16(cal_pres_high[63:48]);
        p9 = ext16(cal_p9);

        a = shr_s(((adc_t >> 3) - (t1 << 1)) * t2, 11);
        d = (adc_t >> 4) - t1;
        b = shr_s(shr_s(d * d, 12) * t3, 14);
        r.fine = a + b;
        r.temp = shr_s(r.fine * 32'd5 + 32'd128, 8);

        a = shr_s(r.fine, 1) - 32'd64000;
        sq = shr_s(a, 2) * shr_s(a, 2);
        b = shr_s(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = shr_s(b, 2) + (p4 << 16);
        a = shr_s(shr_s(p3 * shr_s(sq, 13), 3) + shr_s(p2 * a, 1), 18);
        a = shr_s((32'd32768 + a) * p1, 15);

        if (a == 32'd0) begin
            r.pres = 32'd0;
            r.inv = 1'b1;
        end else begin
            p = ((32'd1048576 - adc_p) - shr_s(b, 12)) * 32'd3125;
            if (p < 32'h8000_0000) begin
                p = (p << 1) / a;
            end else begin
                p = (p / a) * 32'd2;
            end
            sq = (p >> 3) * (p >> 3);
            a = shr_s(p9 * (sq >> 13), 12);
            b = shr_s((p >> 2) * p8, 13);
            r.pres = p + shr_s(a + b + p7, 4);
            r.inv = 1'b0;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            baro_pkg::RegTempCal:  cal_temp = data[47:0];
            baro_pkg::RegPresLow:  cal_pres_low = data;
            baro_pkg::RegPresHigh: cal_pres_high = data;
            baro_pkg::RegPresNine: cal_p9 = data[15:0];
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_cal_set(input int k);
        case (k)
            1: begin
                write_reg(baro_pkg::RegTempCal, 64'({16'hFC18, 16'd26435, 16'd27504}));
                write_reg(baro_pkg::RegPresLow, {16'd2855, 16'd3024, 16'hD643, 16'd36477});
                write_reg(baro_pkg::RegPresHigh, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
                write_reg(baro_pkg::RegPresNine, 64'd6000);
            end
            2: begin
                write_reg(baro_pkg::RegTempCal, 64'({48{1'b1}}));
                write_reg(baro_pkg::RegPresLow, {64{1'b1}});
                write_reg(baro_pkg::RegPresHigh, {64{1'b1}});
                write_reg(baro_pkg::RegPresNine, {64{1'b1}});
            end
            3: begin
                write_reg(baro_pkg::RegTempCal, 64'({16'h8000, 16'h8000, 16'h8000}));
                write_reg(baro_pkg::RegPresLow, {4{16'h8000}});
                write_reg(baro_pkg::RegPresHigh, {4{16'h8000}});
                write_reg(baro_pkg::RegPresNine, 64'h8000);
            end
            4: begin
                write_reg(baro_pkg::RegTempCal, 64'({16'h7FFF, 16'h7FFF, 16'h0000}));
                write_reg(baro_pkg::RegPresLow, {4{16'h7FFF}});
                write_reg(baro_pkg::RegPresHigh, {4{16'h7FFF}});
                write_reg(baro_pkg::RegPresNine, 64'h7FFF);
            end
            default: begin
                write_reg(baro_pkg::RegTempCal, rand64());
                write_reg(baro_pkg::RegPresLow, rand64());
                write_reg(baro_pkg::RegPresHigh, rand64());
                write_reg(baro_pkg::RegPresNine, rand64());
            end
        endcase
    endtask

    task automatic send(input logic [19:0] raw_t, input logic [19:0] raw_p,
                        input bit typed, input t_comp want);
        int gap;
        i_valid <= 1'b1;
        i_raw_temperature <= raw_t;
        i_raw_pressure <= raw_p;
        do @(posedge i_clk); while (o_stall);
        pending_q.push_back(typed ? want : compensate(raw_t, raw_p));
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [19:0] pick_raw(input logic [19:0] center);
        case ($urandom_range(0, 2))
            0: return 20'($urandom());
            1: return center + 20'($urandom_range(0, 8191)) - 20'd4096;
            default: return $urandom_range(0, 1) ? 20'hFFFFF - 20'($urandom_range(0, 15))
                                                 : 20'($urandom_range(0, 15));
        endcase
    endfunction

    localparam t_comp NO_PRES = '{temp: 32'd0, fine: 32'd0, pres: 32'd0, inv: 1'b1};
    localparam t_comp UNUSED = '{temp: 32'd0, fine: 32'd0, pres: 32'd0, inv: 1'b0};

    t_row plan[] = '{
        '{0, 20'h00000, 20'h00000, 1, NO_PRES},
        '{0, 20'hFFFFF, 20'hFFFFF, 1, NO_PRES},
        '{0, 20'h00000, 20'hFFFFF, 1, NO_PRES},
        '{0, 20'hFFFFF, 20'h00000, 1, NO_PRES},
        '{0, 20'h7EED0, 20'h655AC, 1, NO_PRES},
        '{1, 20'h7EED0, 20'h655AC, 0, UNUSED},
        '{1, 20'h00000, 20'h00000, 0, UNUSED},
        '{1, 20'hFFFFF, 20'hFFFFF, 0, UNUSED},
        '{1, 20'h00000, 20'hFFFFF, 0, UNUSED},
        '{1, 20'hFFFFF, 20'h00000, 0, UNUSED},
        '{1, 20'h55555, 20'hAAAAA, 0, UNUSED},
        '{1, 20'hAAAAA, 20'h55555, 0, UNUSED},
        '{2, 20'h00000, 20'h00000, 0, UNUSED},
        '{2, 20'hFFFFF, 20'hFFFFF, 0, UNUSED},
        '{2, 20'h7EED0, 20'h655AC, 0, UNUSED},
        '{3, 20'h00000, 20'hFFFFF, 0, UNUSED},
        '{3, 20'hFFFFF, 20'h00000, 0, UNUSED},
        '{3, 20'h7EED0, 20'h655AC, 0, UNUSED},
        '{4, 20'h00000, 20'h00000, 0, UNUSED},
        '{4, 20'hFFFFF, 20'hFFFFF, 0, UNUSED},
        '{4, 20'h7EED0, 20'h655AC, 0, UNUSED}
    };

    initial begin
        int cur_set;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= baro_pkg::RegTempCal;
        i_cfg_data <= 64'd0;
        i_valid <= 1'b0;
        i_raw_temperature <= 20'd0;
        i_raw_pressure <= 20'd0;
        cal_temp = '0;
        cal_pres_low = '0;
        cal_pres_high = '0;
        cal_p9 = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_set = 0;
        foreach (plan[n]) begin
            if (plan[n].cal_set != cur_set) begin
                i_valid <= 1'b0;
                drain();
                cur_set = plan[n].cal_set;
                load_cal_set(cur_set);
            end
            send(plan[n].raw_t, plan[n].raw_p, plan[n].typed, plan[n].want);
        end

        for (int ph = 0; ph < 12; ph++) begin
            i_valid <= 1'b0;
            drain();
            load_cal_set(ph < 4 ? 1 : (ph < 6 ? ph - 2 : 5));
            // zero pressure divisor now and then
            if (ph % 5 == 4) write_reg(baro_pkg::RegPresLow, rand64() & ~64'hFFFF);
            no_idle = (ph % 3 == 2);
            repeat (48) send(pick_raw(20'h7EED0), pick_raw(20'h655AC), 0, UNUSED);
        end
        i_valid <= 1'b0;
        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        int n;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            do @(posedge i_clk); while (!(o_valid && !i_stall && i_rst_n));
            n = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_comp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                report("unexpected result", o_pressure_pa, 32'd0);
            end else begin
                want = pending_q.pop_front();
                if (o_temperature_centi !== want.temp)
                    report("temperature_centi", o_temperature_centi, want.temp);
                if (o_fine_temperature !== want.fine)
                    report("fine_temperature", o_fine_temperature, want.fine);
                if (o_pressure_pa !== want.pres)
                    report("pressure_pa", o_pressure_pa, want.pres);
                if (o_pressure_invalid !== want.inv)
                    report("pressure_invalid", {31'd0, o_pressure_invalid}, {31'd0, want.inv});
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end
endmodule

FILE: sim.f
hdl/baro_pkg.sv
hdl/baro_divider.sv
hdl/baro_sensor_compensation_top.sv
bench/testbench.sv
